### rtl/tsr_pkg.sv
// tsr_pkg: shared types and constants of the segment reassembler
// item and result beat structs, status codes, controller states, command and status groups
// depends on nothing
package tsr_pkg;

    localparam int UNIT_BYTES = 16;
    localparam int UNIT_SHIFT = 4;
    localparam int MSG_LEN_W  = 13;

    localparam logic KIND_SEGMENT = 1'b0;
    localparam logic KIND_PULL    = 1'b1;
    localparam logic RES_STATUS   = 1'b0;
    localparam logic RES_BYTE     = 1'b1;

    // ST_PENDING doubles as the no-error code of an open segment
    typedef enum logic [2:0] {
        ST_PENDING   = 3'd0,
        ST_COMPLETE  = 3'd1,
        ST_UNALIGNED = 3'd2,
        ST_NO_SLOT   = 3'd3,
        ST_TOO_LARGE = 3'd4,
        ST_BUSY      = 3'd5
    } t_status;

    typedef struct packed {
        logic        kind;
        logic [15:0] svc_id;
        logic [15:0] mth_id;
        logic [15:0] cli_id;
        logic [15:0] ses_id;
        logic [27:0] unit_offset;
        logic        more_segs;
        logic        has_byte;
        logic [7:0]  data_byte;
        logic        segment_end;
    } t_item;

    typedef struct packed {
        logic                 result_kind;
        t_status              status;
        logic [MSG_LEN_W-1:0] message_length;
        logic [7:0]           out_byte;
        logic                 out_last;
    } t_result;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DISPATCH,
        S_CLEAR,
        S_BYTE,
        S_FIN,
        S_WALK,
        S_DONE,
        S_PULL
    } t_state;

    typedef struct packed {
        logic capture;
        logic begin_seg;
        logic clear_step;
        logic byte_step;
        logic finish;
        logic walk_step;
        logic conclude;
        logic pull;
    } t_cmd;

    typedef struct packed {
        logic item_pull;
        logic item_end;
        logic draining;
        logic seg_open;
        logic alloc;
        logic clear_done;
        logic need_walk;
        logic walk_done;
    } t_stat;

endpackage

### rtl/tsr_ctrl.sv
// tsr_ctrl: sequencing state machine of the segment reassembler
// issues datapath commands from datapath status
// depends on tsr_pkg
module tsr_ctrl
    import tsr_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_start,
    input  t_stat i_stat,
    output t_cmd  o_cmd,
    output logic  o_busy
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_busy  = 1'b1;
        case (r_state)
            S_IDLE: begin
                o_busy = 1'b0;
                if (i_start) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                if (i_stat.item_pull) begin
                    n_state = i_stat.draining ? S_PULL : S_IDLE;
                end else if (i_stat.seg_open) begin
                    // continuing segment: store the beat right away
                    o_cmd.byte_step = 1'b1;
                    n_state         = i_stat.item_end ? S_FIN : S_IDLE;
                end else begin
                    o_cmd.begin_seg = 1'b1;
                    n_state         = i_stat.alloc ? S_CLEAR : S_BYTE;
                end
            end
            S_CLEAR: begin
                o_cmd.clear_step = 1'b1;
                if (i_stat.clear_done) begin
                    n_state = S_BYTE;
                end
            end
            S_BYTE: begin
                o_cmd.byte_step = 1'b1;
                n_state         = i_stat.item_end ? S_FIN : S_IDLE;
            end
            S_FIN: begin
                o_cmd.finish = 1'b1;
                n_state      = i_stat.need_walk ? S_WALK : S_IDLE;
            end
            S_WALK: begin
                o_cmd.walk_step = 1'b1;
                if (i_stat.walk_done) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                o_cmd.conclude = 1'b1;
                n_state        = S_IDLE;
            end
            S_PULL: begin
                o_cmd.pull = 1'b1;
                n_state    = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

### rtl/tsr_dp.sv
// tsr_dp: datapath of the segment reassembler
// slot contexts, segment length table, message byte memory, walk and result register
// depends on tsr_pkg
module tsr_dp
    import tsr_pkg::*;
#(
    parameter int CONTEXT_SLOTS     = 4,
    parameter int MAX_MESSAGE_BYTES = 4096
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_item   i_item,
    input  t_cmd    i_cmd,
    output t_stat   o_stat,
    output logic    o_strobe,
    output t_result o_result
);

    localparam int SLOT_UNITS = MAX_MESSAGE_BYTES / UNIT_BYTES;
    localparam int SW   = (CONTEXT_SLOTS > 1) ? $clog2(CONTEXT_SLOTS) : 1;
    localparam int UW   = $clog2(SLOT_UNITS);
    localparam int LW   = $clog2(MAX_MESSAGE_BYTES + 1);
    localparam int EW   = $clog2(MAX_MESSAGE_BYTES + 2);
    localparam int TDEP = CONTEXT_SLOTS * SLOT_UNITS;
    localparam int TAW  = $clog2(TDEP);
    localparam int MDEP = CONTEXT_SLOTS * MAX_MESSAGE_BYTES;
    localparam int MAW  = $clog2(MDEP);

    // captured beat and slot contexts
    t_item            r_item;
    logic [63:0]      r_slot_key [CONTEXT_SLOTS];
    logic [LW-1:0]    r_slot_exp [CONTEXT_SLOTS];
    logic [CONTEXT_SLOTS-1:0] r_slot_busy;
    logic [CONTEXT_SLOTS-1:0] r_slot_last;

    // open segment and drain state
    logic [SW-1:0]    r_cur_slot;
    logic [LW-1:0]    r_count;
    logic [LW-1:0]    r_ptr;
    logic             r_draining;
    logic             r_seg_open;
    logic             r_more;
    logic [27:0]      r_offset;
    t_status          r_code;

    // clear sweep and contiguity walk
    logic [UW-1:0]    r_clr;
    logic [UW:0]      r_wu;
    logic [UW-1:0]    r_wu_d;
    logic             r_wvld;
    logic [LW-1:0]    r_wpos;
    logic             r_wfail;

    // memories
    logic [EW-1:0]    r_tab [TDEP];
    logic [EW-1:0]    r_tab_q;
    logic [7:0]       r_mem [MDEP];
    logic [7:0]       r_mem_q;

    logic             r_strobe;
    t_result          r_result;

    logic [63:0]      item_key;
    logic             hit;
    logic             free;
    logic [SW-1:0]    hit_idx;
    logic [SW-1:0]    free_idx;
    logic             off_big;
    t_status          open_code;
    logic [LW:0]      bpos;
    logic             bpos_big;
    logic             mem_we;
    logic [MAW-1:0]   mem_base;
    logic [MAW-1:0]   mem_waddr;
    logic [MAW-1:0]   mem_raddr;
    logic             unaligned;
    logic             fin_record;
    logic             last_known;
    logic [TAW-1:0]   tab_base;
    logic             tab_we;
    logic [TAW-1:0]   tab_waddr;
    logic [EW-1:0]    tab_wdata;
    logic [TAW-1:0]   tab_raddr;
    logic [LW:0]      unit_pos;
    logic             walk_issue;
    logic             walk_ok;
    logic [LW:0]      ptr_next;
    logic             pull_last;
    logic             n_strobe;
    t_result          n_result;

    // session key of the captured beat
    assign item_key = {r_item.svc_id, r_item.mth_id, r_item.cli_id, r_item.ses_id};

    // session lookup: first busy slot with this key, else first free slot
    always_comb begin
        hit      = 1'b0;
        free     = 1'b0;
        hit_idx  = '0;
        free_idx = '0;
        for (int s = 0; s < CONTEXT_SLOTS; s++) begin
            if (!hit && r_slot_busy[s] && r_slot_key[s] == item_key) begin
                hit     = 1'b1;
                hit_idx = SW'(s);
            end
            if (!free && !r_slot_busy[s]) begin
                free     = 1'b1;
                free_idx = SW'(s);
            end
        end
    end

    assign off_big   = (r_item.unit_offset >= 28'(SLOT_UNITS));
    assign open_code = off_big ? ST_TOO_LARGE : ST_PENDING;

    // byte placement
    assign bpos      = (LW+1)'({r_offset[UW-1:0], {UNIT_SHIFT{1'b0}}}) + (LW+1)'(r_count);
    assign bpos_big  = (bpos >= (LW+1)'(MAX_MESSAGE_BYTES));
    assign mem_we    = i_cmd.byte_step && r_item.has_byte && (r_code == ST_PENDING)
                       && !bpos_big;
    assign mem_base  = MAW'(r_cur_slot) * MAW'(MAX_MESSAGE_BYTES);
    assign mem_waddr = mem_base + MAW'(bpos[LW-1:0]);
    assign mem_raddr = mem_base + MAW'(r_ptr);

    // segment end decisions
    assign unaligned  = r_more && (r_count[UNIT_SHIFT-1:0] != '0);
    assign fin_record = (r_code == ST_PENDING) && !unaligned;
    assign last_known = r_slot_last[r_cur_slot] || !r_more;

    // segment length table ports
    assign tab_base  = TAW'(r_cur_slot) * TAW'(SLOT_UNITS);
    assign tab_we    = i_cmd.clear_step || (i_cmd.finish && fin_record);
    assign tab_waddr = tab_base + (i_cmd.clear_step ? TAW'(r_clr)
                                                    : TAW'(r_offset[UW-1:0]));
    assign tab_wdata = i_cmd.clear_step ? '0 : (EW'(r_count) + EW'(1));
    assign tab_raddr = tab_base + TAW'(r_wu[UW-1:0]);

    assign walk_issue = i_cmd.walk_step && (r_wu < (UW+1)'(SLOT_UNITS));
    assign unit_pos   = (LW+1)'({r_wu_d, {UNIT_SHIFT{1'b0}}});
    assign walk_ok    = !r_wfail && (r_wpos == r_slot_exp[r_cur_slot]);

    assign ptr_next  = (LW+1)'(r_ptr) + (LW+1)'(1);
    assign pull_last = (ptr_next >= (LW+1)'(r_slot_exp[r_cur_slot]));

    always_comb begin
        o_stat            = '0;
        o_stat.item_pull  = (r_item.kind == KIND_PULL);
        o_stat.item_end   = r_item.segment_end;
        o_stat.draining   = r_draining;
        o_stat.seg_open   = r_seg_open;
        o_stat.alloc      = !r_draining && !hit && free;
        o_stat.clear_done = (r_clr == UW'(SLOT_UNITS - 1));
        o_stat.need_walk  = fin_record && last_known;
        o_stat.walk_done  = r_wvld && (r_wu_d == UW'(SLOT_UNITS - 1));
    end

    // result beat
    always_comb begin
        n_strobe = 1'b0;
        n_result = '0;
        n_result.result_kind = RES_STATUS;
        n_result.status      = ST_PENDING;
        if (i_cmd.finish) begin
            if (r_code != ST_PENDING) begin
                n_strobe        = 1'b1;
                n_result.status = r_code;
            end else if (unaligned) begin
                n_strobe        = 1'b1;
                n_result.status = ST_UNALIGNED;
            end else if (!last_known) begin
                n_strobe = 1'b1;
            end
        end else if (i_cmd.conclude) begin
            n_strobe = 1'b1;
            if (walk_ok) begin
                n_result.status         = ST_COMPLETE;
                n_result.message_length = MSG_LEN_W'(r_wpos);
            end
        end else if (i_cmd.pull) begin
            n_strobe             = 1'b1;
            n_result.result_kind = RES_BYTE;
            n_result.out_byte    = r_mem_q;
            n_result.out_last    = pull_last;
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot_busy <= '0;
            r_slot_last <= '0;
            r_cur_slot  <= '0;
            r_count     <= '0;
            r_ptr       <= '0;
            r_draining  <= 1'b0;
            r_seg_open  <= 1'b0;
            r_more      <= 1'b0;
            r_offset    <= '0;
            r_code      <= ST_PENDING;
            r_clr       <= '0;
            r_wu        <= '0;
            r_wu_d      <= '0;
            r_wvld      <= 1'b0;
            r_wpos      <= '0;
            r_wfail     <= 1'b0;
            r_strobe    <= 1'b0;
        end else begin
            r_strobe <= n_strobe;
            if (i_cmd.begin_seg) begin
                r_seg_open <= 1'b1;
                r_count    <= '0;
                r_more     <= r_item.more_segs;
                r_offset   <= r_item.unit_offset;
                r_clr      <= '0;
                if (r_draining) begin
                    r_code <= ST_BUSY;
                end else if (hit) begin
                    r_cur_slot <= hit_idx;
                    r_code     <= open_code;
                end else if (free) begin
                    r_cur_slot            <= free_idx;
                    r_code                <= open_code;
                    r_slot_busy[free_idx] <= 1'b1;
                    r_slot_last[free_idx] <= 1'b0;
                end else begin
                    r_code <= ST_NO_SLOT;
                end
            end
            if (i_cmd.clear_step) begin
                r_clr <= r_clr + UW'(1);
            end
            if (i_cmd.byte_step) begin
                if (r_item.has_byte && r_code == ST_PENDING) begin
                    if (bpos_big) begin
                        r_code <= ST_TOO_LARGE;
                    end else begin
                        r_count <= r_count + LW'(1);
                    end
                end
                if (r_item.segment_end) begin
                    r_seg_open <= 1'b0;
                end
            end
            if (i_cmd.finish) begin
                r_wu    <= '0;
                r_wvld  <= 1'b0;
                r_wpos  <= '0;
                r_wfail <= 1'b0;
                if (r_code == ST_TOO_LARGE || (r_code == ST_PENDING && unaligned)) begin
                    r_slot_busy[r_cur_slot] <= 1'b0;
                end else if (fin_record && !r_more) begin
                    r_slot_last[r_cur_slot] <= 1'b1;
                end
            end
            if (i_cmd.walk_step) begin
                r_wvld <= walk_issue;
                r_wu_d <= r_wu[UW-1:0];
                if (walk_issue) begin
                    r_wu <= r_wu + (UW+1)'(1);
                end
                if (r_wvld && !r_wfail && r_tab_q != '0) begin
                    if (unit_pos != (LW+1)'(r_wpos)) begin
                        r_wfail <= 1'b1;
                    end else begin
                        r_wpos <= r_wpos + LW'(r_tab_q - EW'(1));
                    end
                end
            end
            if (i_cmd.conclude && walk_ok) begin
                if (r_wpos == '0) begin
                    r_slot_busy[r_cur_slot] <= 1'b0;
                end else begin
                    r_draining <= 1'b1;
                    r_ptr      <= '0;
                end
            end
            if (i_cmd.pull) begin
                r_ptr <= ptr_next[LW-1:0];
                if (pull_last) begin
                    r_draining              <= 1'b0;
                    r_slot_busy[r_cur_slot] <= 1'b0;
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_result <= n_result;
        if (i_cmd.capture) begin
            r_item <= i_item;
        end
        if (i_cmd.begin_seg && !r_draining && !hit && free) begin
            r_slot_key[free_idx] <= item_key;
            r_slot_exp[free_idx] <= '0;
        end
        if (i_cmd.finish && fin_record && !r_more) begin
            r_slot_exp[r_cur_slot] <= LW'(bpos);
        end
    end

    // segment length table, one write and one registered read
    always_ff @(posedge i_clk) begin
        if (tab_we) begin
            r_tab[tab_waddr] <= tab_wdata;
        end
        r_tab_q <= r_tab[tab_raddr];
    end

    // message byte memory, read port follows the drain pointer
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= r_item.data_byte;
        end
        r_mem_q <= r_mem[mem_raddr];
    end

    assign o_strobe = r_strobe;
    assign o_result = r_result;

endmodule

### rtl/tp_segment_reassembler_unit.sv
// tp_segment_reassembler_unit: top level of the transport segment reassembler
// joins the sequencing controller and the datapath
// depends on tsr_pkg, tsr_ctrl, tsr_dp
//
//   channel | ports                      | handshake
//   --------+----------------------------+------------------------------------
//   item    | i_item (t_item)            | beat taken when i_start && !o_busy
//   result  | o_result (t_result)        | beat valid while o_strobe, one cycle
//
// a byte beat of an open segment is stored from S_DISPATCH; the first beat of a segment
// goes through S_DISPATCH and S_BYTE, plus a sweep (S_CLEAR) of the MAX_MESSAGE_BYTES/16
// length table entries when a new session opens a slot
// a segment end adds S_FIN, then S_WALK and S_DONE when the segment is recorded and the last segment
// of the message is known, for the walk through the length table memory (one read port)
// a drain pull goes through S_DISPATCH and S_PULL, for the registered read of the byte memory
// reset is synchronous and active low; no clearing pass is needed after reset
// results cannot be held off: each beat sits on o_result for exactly one cycle
module tp_segment_reassembler_unit
    import tsr_pkg::*;
#(
    parameter int CONTEXT_SLOTS     = 4,
    parameter int MAX_MESSAGE_BYTES = 4096
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_start,
    output logic    o_busy,
    input  t_item   i_item,
    output logic    o_strobe,
    output t_result o_result
);

    // command and status groups between controller and datapath
    t_cmd  cmd;
    t_stat stat;

    tsr_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .o_busy  (o_busy)
    );

    tsr_dp #(
        .CONTEXT_SLOTS     (CONTEXT_SLOTS),
        .MAX_MESSAGE_BYTES (MAX_MESSAGE_BYTES)
    ) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (i_item),
        .i_cmd    (cmd),
        .o_stat   (stat),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

endmodule

### bench/testbench.sv
// testbench: self-checking bench for tp_segment_reassembler_unit
// holds a reassembly predictor in a small scoreboard class; depends on tsr_pkg and the rtl
`timescale 1ns / 1ps

module testbench
    import tsr_pkg::*;
();

    localparam int SLOTS      = 4;
    localparam int MAX_BYTES  = 4096;
    localparam int UNITS      = MAX_BYTES / UNIT_BYTES;
    localparam int STALL_LIMIT = 20000;

    int fail_count;
    int status_seen;
    int bytes_seen;
    int complete_seen;

    // mismatch report: one line per failure
    task automatic report_mismatch(input string what);
        $display("mismatch: %s", what);
        fail_count++;
    endtask

    // predictor of the reassembler plus the queue of results it expects
    class reassembly_board;
        logic [63:0]          key_of [SLOTS];
        bit                   busy_of [SLOTS];
        bit                   last_of [SLOTS];
        int unsigned          total_of [SLOTS];
        int unsigned          len_tab [SLOTS][UNITS];
        logic [7:0]           bytes_of [SLOTS][MAX_BYTES];
        int unsigned          cur_slot;
        int unsigned          cur_count;
        int unsigned          drain_ptr;
        bit                   draining;
        bit                   seg_open;
        bit                   seg_more;
        int unsigned          seg_off;
        t_status              seg_err;
        t_result              pending_q[$];

        function automatic void push_status(t_status st, int unsigned len);
            t_result r;
            r = '0;
            r.result_kind = RES_STATUS;
            r.status = st;
            r.message_length = len[MSG_LEN_W-1:0];
            pending_q = {pending_q, r};
        endfunction

        function automatic void open_segment(t_item it);
            logic [63:0] k;
            int found;
            found = -1;
            seg_open = 1;
            cur_count = 0;
            seg_more = it.more_segs;
            seg_off = 32'(it.unit_offset);
            if (draining) begin
                seg_err = ST_BUSY;
                return;
            end
            k = {it.svc_id, it.mth_id, it.cli_id, it.ses_id};
            for (int s = 0; s < SLOTS; s++)
                if (found < 0 && busy_of[s] && key_of[s] == k) found = s;
            for (int s = 0; s < SLOTS; s++)
                if (found < 0 && !busy_of[s]) begin
                    found = s;
                    busy_of[s] = 1;
                    key_of[s] = k;
                    last_of[s] = 0;
                    total_of[s] = 0;
                    for (int u = 0; u < UNITS; u++) len_tab[s][u] = 0;
                end
            if (found < 0) begin
                seg_err = ST_NO_SLOT;
                return;
            end
            cur_slot = found;
            seg_err = (seg_off >= UNITS) ? ST_TOO_LARGE : ST_PENDING;
        endfunction

        function automatic void close_segment();
            int unsigned pos;
            bit ok;
            pos = 0;
            ok = 1;
            if (seg_err == ST_BUSY || seg_err == ST_NO_SLOT) begin
                push_status(seg_err, 0);
                return;
            end
            if (seg_err == ST_TOO_LARGE) begin
                busy_of[cur_slot] = 0;
                push_status(ST_TOO_LARGE, 0);
                return;
            end
            if (seg_more && (cur_count % UNIT_BYTES) != 0) begin
                busy_of[cur_slot] = 0;
                push_status(ST_UNALIGNED, 0);
                return;
            end
            len_tab[cur_slot][seg_off] = cur_count + 1;
            if (!seg_more) begin
                last_of[cur_slot] = 1;
                total_of[cur_slot] = seg_off * UNIT_BYTES + cur_count;
            end
            if (!last_of[cur_slot]) begin
                push_status(ST_PENDING, 0);
                return;
            end
            for (int u = 0; u < UNITS; u++) begin
                if (len_tab[cur_slot][u] == 0) continue;
                if (u * UNIT_BYTES != pos) begin
                    ok = 0;
                    break;
                end
                pos += len_tab[cur_slot][u] - 1;
            end
            if (!ok || pos != total_of[cur_slot]) begin
                push_status(ST_PENDING, 0);
                return;
            end
            if (pos == 0) busy_of[cur_slot] = 0;
            else begin
                draining = 1;
                drain_ptr = 0;
            end
            push_status(ST_COMPLETE, pos);
        endfunction

        // note one accepted input beat
        function automatic void note_item(t_item it);
            t_result r;
            int unsigned p;
            if (it.kind == KIND_PULL) begin
                if (!draining) return;
                r = '0;
                r.result_kind = RES_BYTE;
                r.status = ST_PENDING;
                r.out_byte = bytes_of[cur_slot][drain_ptr % MAX_BYTES];
                drain_ptr++;
                r.out_last = (drain_ptr >= total_of[cur_slot]);
                if (r.out_last) begin
                    draining = 0;
                    busy_of[cur_slot] = 0;
                end
                pending_q = {pending_q, r};
                return;
            end
            if (!seg_open) open_segment(it);
            if (it.has_byte && seg_err == ST_PENDING) begin
                p = seg_off * UNIT_BYTES + cur_count;
                if (p >= MAX_BYTES) seg_err = ST_TOO_LARGE;
                else begin
                    bytes_of[cur_slot][p] = it.data_byte;
                    cur_count++;
                end
            end
            if (!it.segment_end) return;
            seg_open = 0;
            close_segment();
        endfunction

        // check one result beat against the oldest expectation
        task automatic check_result(t_result got);
            t_result exp_r;
            if (pending_q.size() == 0) begin
                report_mismatch($sformatf("unexpected result %h", got));
                return;
            end
            exp_r = pending_q.pop_front();
            if (got.result_kind == RES_STATUS) status_seen++;
            else bytes_seen++;
            if (got.result_kind == RES_STATUS && got.status == ST_COMPLETE) complete_seen++;
            if (got.result_kind !== exp_r.result_kind)
                report_mismatch($sformatf("kind got %b exp %b", got.result_kind,
                                          exp_r.result_kind));
            if (got.status !== exp_r.status)
                report_mismatch($sformatf("status got %0d exp %0d", got.status,
                                          exp_r.status));
            if (got.message_length !== exp_r.message_length)
                report_mismatch($sformatf("length got %0d exp %0d", got.message_length,
                                          exp_r.message_length));
            if (got.out_byte !== exp_r.out_byte)
                report_mismatch($sformatf("byte got %h exp %h", got.out_byte,
                                          exp_r.out_byte));
            if (got.out_last !== exp_r.out_last)
                report_mismatch($sformatf("last got %b exp %b", got.out_last,
                                          exp_r.out_last));
        endtask
    endclass

    logic    i_clk;
    logic    i_rst_n;
    logic    i_start;
    logic    o_busy;
    t_item   i_item;
    logic    o_strobe;
    t_result o_result;

    reassembly_board board;
    int      idle_cycles;
    int      items_sent;

    tp_segment_reassembler_unit #(
        .CONTEXT_SLOTS(SLOTS),
        .MAX_MESSAGE_BYTES(MAX_BYTES)
    ) i_dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_start(i_start),
        .o_busy(o_busy),
        .i_item(i_item),
        .o_strobe(o_strobe),
        .o_result(o_result)
    );

    // 20 ns clock
    initial i_clk = 1'b0;
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // sample the block at each rising edge: accepted beats and result beats
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_start && !o_busy) begin
                board.note_item(i_item);
                idle_cycles <= 0;
            end else if (o_strobe) idle_cycles <= 0;
            else idle_cycles <= idle_cycles + 1;
            if (o_strobe) board.check_result(o_result);
        end
    end

    // watchdog on cycles with no beat moving
    always @(posedge i_clk) begin
        if (idle_cycles >= STALL_LIMIT) begin
            $display("watchdog: no progress for %0d cycles", STALL_LIMIT);
            $display("TEST FAILED");
            $finish;
        end
    end

    // drive one beat and hold it until the block takes it
    task automatic send_beat(input t_item it, input bit allow_gap);
        int gap;
        gap = 0;
        if (allow_gap && $urandom_range(0, 3) != 0) gap = $urandom_range(0, 16);
        repeat (gap) @(posedge i_clk);
        i_item <= it;
        i_start <= 1'b1;
        do @(posedge i_clk); while (o_busy);
        items_sent++;
        // drop start at the accepting edge; the block stays busy for the next cycle
        i_start <= 1'b0;
        @(posedge i_clk);
    endtask

    // build a segment header beat for a session key
    function automatic t_item seg_item(logic [63:0] k, int unsigned off, bit more);
        t_item it;
        it = '0;
        it.kind = KIND_SEGMENT;
        {it.svc_id, it.mth_id, it.cli_id, it.ses_id} = k;
        it.unit_offset = 28'(off);
        it.more_segs = more;
        return it;
    endfunction

    // send one whole segment of n bytes; n == 0 gives a single empty end beat
    task automatic send_segment(logic [63:0] k, int unsigned off, bit more, int n,
                                bit gaps);
        t_item it;
        it = seg_item(k, off, more);
        if (n == 0) begin
            it.has_byte = 1'b0;
            it.data_byte = 8'($urandom);
            it.segment_end = 1'b1;
            send_beat(it, gaps);
            return;
        end
        for (int b = 0; b < n; b++) begin
            it.has_byte = 1'b1;
            it.data_byte = 8'($urandom);
            it.segment_end = (b == n - 1);
            // later beats carry random header noise, which the block ignores
            if (b > 0) begin
                it.unit_offset = 28'($urandom);
                it.svc_id = 16'($urandom);
                it.more_segs = 1'($urandom);
            end
            send_beat(it, gaps && $urandom_range(0, 7) == 0);
        end
    endtask

    // send n pull beats; a pull while no drain runs gives no result
    task automatic pull_bytes(int n, bit gaps);
        t_item it;
        for (int i = 0; i < n; i++) begin
            it = '0;
            it.kind = KIND_PULL;
            it.data_byte = 8'($urandom);
            send_beat(it, gaps && $urandom_range(0, 5) == 0);
        end
    endtask

    task automatic drain_all(bit gaps);
        while (board.draining) pull_bytes(1, gaps);
    endtask

    // a well-formed message cut into aligned segments sent out of order
    task automatic send_message(logic [63:0] k, bit gaps);
        int units, tail, order[$], j;
        units = $urandom_range(0, 4);
        tail = $urandom_range(0, 20);
        if ($urandom_range(0, 40) == 0) units = $urandom_range(8, 24);
        for (int u = 0; u < units; u++) order = {order, u};
        order.shuffle();
        j = $urandom_range(0, units);
        order.insert(j, -1);
        foreach (order[i]) begin
            if (order[i] < 0) send_segment(k, units, 1'b0, tail, gaps);
            else send_segment(k, order[i], 1'b1, UNIT_BYTES, gaps);
            if ($urandom_range(0, 15) == 0)
                send_segment(k, order[i] < 0 ? 0 : order[i], 1'b1, UNIT_BYTES, gaps);
        end
        drain_all(gaps);
    endtask

    function automatic logic [63:0] rand_key();
        // a few small keys so sessions collide and interleave
        if ($urandom_range(0, 3) != 0) return {48'd0, 14'd0, 2'($urandom_range(0, 5))};
        return {$urandom, $urandom};
    endfunction

    // wait for all expected results, then a quiet stretch for the walk
    task automatic settle();
        while (board.pending_q.size() != 0) @(posedge i_clk);
        repeat (UNITS + 40) @(posedge i_clk);
    endtask

    initial begin
        logic [63:0] ka;
        t_item it;
        fail_count = 0;
        status_seen = 0;
        bytes_seen = 0;
        complete_seen = 0;
        idle_cycles = 0;
        items_sent = 0;
        board = new();
        i_rst_n <= 1'b0;
        i_start <= 1'b0;
        i_item <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: pull when idle, empty complete message, extremes of the key
        pull_bytes(1, 1'b0);
        send_segment('0, 0, 1'b0, 0, 1'b0);
        ka = '1;
        send_segment(ka, 0, 1'b1, UNIT_BYTES, 1'b0);
        send_segment(ka, 1, 1'b0, 3, 1'b0);
        // segment while draining is rejected busy
        send_segment(64'h1234, 0, 1'b0, 1, 1'b0);
        drain_all(1'b0);
        // unaligned drop, too-large offset at the limit and at the field maximum
        send_segment(64'h5, 0, 1'b1, 5, 1'b0);
        send_segment(64'h6, UNITS, 1'b0, 1, 1'b0);
        send_segment(64'h7, 28'hFFFFFFF, 1'b1, 0, 1'b0);
        // byte crossing the end of the area
        send_segment(64'h8, UNITS - 1, 1'b0, UNIT_BYTES + 1, 1'b0);
        // fill every slot, then overflow
        for (int s = 0; s < SLOTS; s++)
            send_segment(64'h100 + s, 0, 1'b1, UNIT_BYTES, 1'b0);
        send_segment(64'h200, 0, 1'b1, UNIT_BYTES, 1'b0);
        // a gap keeps them pending; the gap fill completes the first, the rest get busy
        for (int s = 0; s < SLOTS; s++) send_segment(64'h100 + s, 3, 1'b0, 2, 1'b0);
        for (int s = 0; s < SLOTS; s++) send_segment(64'h100 + s, 1, 1'b1, 32, 1'b0);
        drain_all(1'b0);
        settle();

        // random: mostly whole messages, some noise and broken segments
        while (items_sent < 1500) begin
            case ($urandom_range(0, 9))
                0: send_segment(rand_key(), $urandom_range(0, 3), 1'($urandom),
                                $urandom_range(0, 40), 1'b1);
                1: pull_bytes($urandom_range(1, 3), 1'b1);
                2: begin
                    it = '0;
                    it.kind = KIND_SEGMENT;
                    {it.svc_id, it.mth_id, it.cli_id, it.ses_id} =
                        {$urandom, $urandom};
                    it.unit_offset = 28'($urandom);
                    it.more_segs = 1'($urandom);
                    it.has_byte = 1'($urandom);
                    it.data_byte = 8'($urandom);
                    it.segment_end = 1'b1;
                    send_beat(it, 1'b1);
                end
                default: send_message(rand_key(), $urandom_range(0, 2) != 0);
            endcase
            // occasionally flush everything so slots free up
            if ($urandom_range(0, 30) == 0) begin
                drain_all(1'b1);
                for (int s = 0; s < SLOTS; s++)
                    if (board.busy_of[s]) send_segment(board.key_of[s], 0, 1'b1, 3, 1'b1);
            end
        end
        drain_all(1'b1);

        settle();
        $display("covered %0d beats: %0d status results (%0d complete), %0d drained bytes",
                 items_sent, status_seen, complete_seen, bytes_seen);
        if (fail_count == 0 && board.pending_q.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("%0d mismatches, %0d results never seen", fail_count,
                     board.pending_q.size());
            $display("TEST FAILED");
        end
        $finish;
    end
endmodule
